@@ sv/ts_pcr_pkg.sv @@
package ts_pcr_pkg;

  // field widths
  localparam int PID_W      = 13;
  localparam int CFG_PID_W  = 14;
  localparam int PPP_W      = 7;
  localparam int BASE_W     = 33;
  localparam int EXT_W      = 9;
  localparam int PCR_W      = 42;
  localparam int DIFF_W     = 45;
  localparam int SLOPE_W    = 24;  // slope never exceeds the 500 ms gap limit
  localparam int CNT_W      = 6;   // group counts up to 32
  localparam int PROD_W     = SLOPE_W + CNT_W;
  localparam int DUR_W      = 29;  // slope * 32 stays below 2^29
  localparam int NUM_W      = 34;  // duration * 32 stays below 2^34
  localparam int CLK_W      = 64;
  localparam int PEND_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_PID_W-1:0] ANY_PID    = 14'd8192;
  localparam logic [CFG_PID_W-1:0] PID_RESET  = ANY_PID;
  localparam logic [PPP_W-1:0]     PPP_RESET  = 7'd7;
  localparam logic [PCR_W-1:0]     PCR_MUL    = 42'd300;
  localparam logic [DIFF_W-1:0]    GAP_LIMIT  = 45'd13500000;
  localparam logic [DIFF_W-1:0]    WRAP_SPAN  = 45'd2576980377600;
  localparam logic signed [PEND_W-1:0] PEND_MAX = 32'sh7FFF_FFFF;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_END    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PCR_PID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PPP     = 2'd1;

  typedef enum logic [1:0] {
    KIND_STAMP     = 2'd0,
    KIND_SYNC_LOST = 2'd1,
    KIND_NO_PCR    = 2'd2
  } kind_t;

  typedef struct packed {
    logic              operation;
    logic              sync_ok;
    logic [PID_W-1:0]  pid;
    logic              has_pcr;
    logic [BASE_W-1:0] pcr_base;
    logic [EXT_W-1:0]  pcr_ext;
  } item_t;

  typedef struct packed {
    kind_t            kind;
    logic [CLK_W-1:0] timestamp;
    logic             last;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ sv/ts_pcr_payload_timestamper_top.sv @@
// A plain packet only bumps the pending count; a selected PCR works out its slope
// and counts pending groups, or if it is the first PCR only records the backlog.
// Stamping PCR: groups are counted, then each stamp goes through the 34-step
// shared divider; the first one stamps the backlog first, with a scaled duration.
// End of stream: groups counted, duration scaled, each stamped; errors are direct.
// One item in flight. rst (sync, active high) loads defaults, clears stream and halt.
module ts_pcr_payload_timestamper_top #(
  parameter int MAX_PAYLOADS_PER_PCR = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  ts_pcr_pkg::item_t                    item,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output ts_pcr_pkg::result_t                  result,
  input  logic                                 cfg_wen,
  input  logic [ts_pcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ts_pcr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ts_pcr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PCR_DIFF,
    S_PCR_SLOPE,
    S_COUNT,
    S_DUR_MUL,
    S_DUR_GO,
    S_DUR_WAIT,
    S_EMIT_STEP,
    S_EMIT_GO,
    S_EMIT_WAIT,
    S_EMIT_PUSH
  } state_t;

  // why groups are being counted
  typedef enum logic [1:0] {
    M_FIRST,   // first PCR: only record the backlog
    M_END,     // end of stream flush
    M_PCR      // regular PCR
  } mode_t;

  // what follows the current run of stamps
  typedef enum logic [1:0] {
    P_END,     // flush done, reset stream state
    P_FIRST,   // CBR backlog done, now stamp the current groups
    P_PCR      // current groups done
  } post_t;

  state_t state;
  mode_t  mode;
  post_t  post;

  // configuration
  logic [CFG_PID_W-1:0] pcr_pid;
  logic [PPP_W-1:0]     ppp;

  // stream state
  logic [PCR_W-1:0]         prev_pcr;
  logic                     pcr_valid;
  logic [SLOPE_W-1:0]       slope;
  logic signed [PEND_W-1:0] pending;
  logic                     first_out;
  logic [CNT_W-1:0]         prev_count;
  logic [CLK_W-1:0]         clock;
  logic                     halted;

  // per-item working registers
  item_t              itm;
  logic [PCR_W-1:0]   pcr;
  logic [DIFF_W-1:0]  diff_wrap;
  logic [DIFF_W-1:0]  diff;
  logic [CNT_W-1:0]   groups;
  logic [CNT_W-1:0]   mul_b;
  logic [CNT_W-1:0]   den;
  logic [PROD_W-1:0]  product;
  logic [DUR_W-1:0]   dur;
  logic [NUM_W-1:0]   acc;
  logic [CNT_W-1:0]   emit_n;
  logic [CNT_W-1:0]   emit_i;
  logic               emit_final;

  logic               out_free;
  logic               result_push;
  logic               pid_hit;
  logic               count_go;
  logic [PPP_W-1:0]   grp;
  logic [PCR_W-1:0]   pcr_calc;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // one item in flight at a time; new transfers only while idle
  assign item_stall = (state != S_IDLE);
  // output register can take a new result this cycle
  assign out_free   = !result_valid || !result_stall;
  // a new result is loaded into the output register this cycle
  assign result_push = out_free &&
                       ((state == S_EMIT_PUSH) ||
                        ((state == S_DECODE) && (itm.operation == OP_END) && (slope == '0)) ||
                        ((state == S_DECODE) && (itm.operation != OP_END) && !itm.sync_ok));

  // packets_per_payload of zero behaves as one
  assign grp      = (ppp == '0) ? PPP_W'(1) : ppp;
  assign pid_hit  = (pcr_pid == ANY_PID) || (pcr_pid == {1'b0, itm.pid});
  assign pcr_calc = PCR_W'(itm.pcr_base) * PCR_MUL + PCR_W'(itm.pcr_ext);

  // ceil(pending / grp) by repeated subtraction; the leftover is what
  // take-groups would leave behind, including the saturated case
  assign count_go = (pending > 32'sd0) && (groups < CNT_W'(MAX_PAYLOADS_PER_PCR));

  // shared divider: duration scaling and every interpolated stamp
  assign div_req.start    = (state == S_DUR_GO) || (state == S_EMIT_GO);
  assign div_req.dividend = (state == S_EMIT_GO) ? acc : NUM_W'(product);
  assign div_req.divisor  = (state == S_EMIT_GO) ? emit_n : den;

  ts_pcr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      pcr_pid      <= PID_RESET;
      ppp          <= PPP_RESET;
      pcr_valid    <= 1'b0;
      prev_pcr     <= '0;
      slope        <= '0;
      pending      <= '0;
      first_out    <= 1'b1;
      prev_count   <= '0;
      clock        <= '0;
      halted       <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_PCR_PID: pcr_pid <= cfg_data;
          CFG_PPP:     ppp     <= cfg_data[PPP_W-1:0];
          default: ;
        endcase
      end

      if (result_valid && !result_stall && !result_push) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            itm   <= item;
            // once halted, items are taken and dropped
            state <= halted ? S_IDLE : S_DECODE;
          end
        end

        S_DECODE: begin
          if (itm.operation == OP_END) begin
            if (slope == '0) begin
              // never saw two PCRs: report and drop the stream
              if (out_free) begin
                result_valid <= 1'b1;
                result       <= '{kind: KIND_NO_PCR, timestamp: '0, last: 1'b1};
                pcr_valid    <= 1'b0;
                prev_pcr     <= '0;
                slope        <= '0;
                pending      <= '0;
                first_out    <= 1'b1;
                prev_count   <= '0;
                clock        <= '0;
                state        <= S_IDLE;
              end
            end else begin
              groups <= '0;
              mode   <= M_END;
              state  <= S_COUNT;
            end
          end else if (!itm.sync_ok) begin
            if (out_free) begin
              result_valid <= 1'b1;
              result       <= '{kind: KIND_SYNC_LOST, timestamp: '0, last: 1'b1};
              halted       <= 1'b1;
              state        <= S_IDLE;
            end
          end else begin
            if (pending != PEND_MAX) begin
              pending <= pending + 32'sd1;
            end
            pcr   <= pcr_calc;
            state <= (pid_hit && itm.has_pcr) ? S_PCR_DIFF : S_IDLE;
          end
        end

        S_PCR_DIFF: begin
          if (!pcr_valid) begin
            // first PCR: record it and count the backlog
            prev_pcr  <= pcr;
            pcr_valid <= 1'b1;
            groups    <= '0;
            mode      <= M_FIRST;
            state     <= S_COUNT;
          end else begin
            diff_wrap <= WRAP_SPAN + DIFF_W'(pcr) - DIFF_W'(prev_pcr);
            diff      <= DIFF_W'(pcr) - DIFF_W'(prev_pcr);
            state     <= S_PCR_SLOPE;
          end
        end

        S_PCR_SLOPE: begin
          if (!diff_wrap[DIFF_W-1] && (diff_wrap < GAP_LIMIT)) begin
            // PCR wrapped past 2^33 * 300
            slope <= diff_wrap[SLOPE_W-1:0];
          end else if (!(diff[DIFF_W-1] || (diff == '0) || (diff > GAP_LIMIT))) begin
            slope <= diff[SLOPE_W-1:0];
          end
          // otherwise a discontinuity: the old slope stays
          prev_pcr <= pcr;
          if (pending > 32'sd0) begin
            groups <= '0;
            mode   <= M_PCR;
            state  <= S_COUNT;
          end else begin
            state <= S_IDLE;
          end
        end

        S_COUNT: begin
          if (count_go) begin
            pending <= pending - PEND_W'(grp);
            groups  <= groups + CNT_W'(1);
          end else begin
            case (mode)
              M_FIRST: begin
                prev_count <= groups;
                state      <= S_IDLE;
              end
              M_END: begin
                if (prev_count == '0) begin
                  dur        <= '0;
                  emit_n     <= groups;
                  emit_i     <= '0;
                  acc        <= '0;
                  emit_final <= 1'b1;
                  post       <= P_END;
                  state      <= S_EMIT_STEP;
                end else begin
                  // flush duration = slope * groups / prev_count
                  mul_b <= groups;
                  den   <= prev_count;
                  state <= S_DUR_MUL;
                end
              end
              M_PCR: begin
                if (first_out) begin
                  // backlog duration = slope * prev_count / groups
                  mul_b <= prev_count;
                  den   <= groups;
                  state <= S_DUR_MUL;
                end else begin
                  dur        <= DUR_W'(slope);
                  emit_n     <= groups;
                  emit_i     <= '0;
                  acc        <= '0;
                  emit_final <= 1'b1;
                  post       <= P_PCR;
                  state      <= S_EMIT_STEP;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_DUR_MUL: begin
          product <= PROD_W'(slope) * PROD_W'(mul_b);
          state   <= S_DUR_GO;
        end

        S_DUR_GO: begin
          state <= S_DUR_WAIT;
        end

        S_DUR_WAIT: begin
          if (div_rsp.done) begin
            dur    <= div_rsp.quotient[DUR_W-1:0];
            emit_i <= '0;
            acc    <= '0;
            if (mode == M_END) begin
              emit_n     <= groups;
              emit_final <= 1'b1;
              post       <= P_END;
            end else begin
              emit_n     <= prev_count;
              emit_final <= 1'b0;
              post       <= P_FIRST;
            end
            state <= S_EMIT_STEP;
          end
        end

        S_EMIT_STEP: begin
          if (emit_i == emit_n) begin
            // run finished (or empty): clock moves by the whole duration, or resets at end
            case (post)
              P_END: begin
                pcr_valid  <= 1'b0;
                prev_pcr   <= '0;
                slope      <= '0;
                pending    <= '0;
                first_out  <= 1'b1;
                prev_count <= '0;
                clock      <= '0;
                state      <= S_IDLE;
              end
              P_FIRST: begin
                clock      <= clock + CLK_W'(dur);
                first_out  <= 1'b0;
                dur        <= DUR_W'(slope);
                emit_n     <= groups;
                emit_i     <= '0;
                acc        <= '0;
                emit_final <= 1'b1;
                post       <= P_PCR;
              end
              P_PCR: begin
                clock      <= clock + CLK_W'(dur);
                prev_count <= groups;
                state      <= S_IDLE;
              end
              default: state <= S_IDLE;
            endcase
          end else begin
            // acc tracks dur * i without a multiplier
            acc    <= acc + NUM_W'(dur);
            emit_i <= emit_i + CNT_W'(1);
            state  <= S_EMIT_GO;
          end
        end

        S_EMIT_GO: begin
          state <= S_EMIT_WAIT;
        end

        S_EMIT_WAIT: begin
          if (div_rsp.done) begin
            state <= S_EMIT_PUSH;
          end
        end

        S_EMIT_PUSH: begin
          // quotient holds in the divider until its next start
          if (out_free) begin
            result_valid <= 1'b1;
            result       <= '{kind:      KIND_STAMP,
                              timestamp: clock + CLK_W'(div_rsp.quotient),
                              last:      emit_final && (emit_i == emit_n)};
            state        <= S_EMIT_STEP;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/ts_pcr_div.sv @@
module ts_pcr_div (
  input  logic                 clk,
  input  logic                 rst,
  input  ts_pcr_pkg::div_req_t req,
  output ts_pcr_pkg::div_rsp_t rsp
);
  import ts_pcr_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  den;
  logic [NUM_W-1:0]  quo;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    trial;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem, quo[NUM_W-1]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
        rem   <= '0;
        den   <= req.divisor;
        quo   <= req.dividend;
      end else if (busy) begin
        if (shifted >= {1'b0, den}) begin
          rem <= trial[CNT_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= shifted[CNT_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ sv/ts_pcr_chk.sv @@
module ts_pcr_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              item_stall,
  input logic                              result_valid,
  input logic                              result_stall,
  input ts_pcr_pkg::result_t               result
);
  import ts_pcr_pkg::*;

  logic halt_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      halt_seen <= 1'b0;
    end else if (result_valid && !result_stall && result.kind == KIND_SYNC_LOST) begin
      halt_seen <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind != KIND_STAMP |-> result.last && result.timestamp == '0)
    else $error("error result not single or carries a timestamp");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> item_stall)
    else $error("item taken in the middle of a stamp burst");

  a_halt: assert property (@(posedge clk) disable iff (rst)
    halt_seen |-> !result_valid)
    else $error("result after sync loss");

endmodule

bind ts_pcr_payload_timestamper_top ts_pcr_chk u_chk (.*);
